@@ rtl/core/periodicity_epoch_detector_macros.svh @@
// Assertion macros used by the checker file of the epoch detector
`ifndef PERIODICITY_EPOCH_DETECTOR_MACROS_SVH
`define PERIODICITY_EPOCH_DETECTOR_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define PED_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define PED_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ped_pkg.sv @@
// Shared types, codes and constants of the periodicity epoch detector
package ped_pkg;

    localparam int unsigned SIG_W    = 64;
    localparam int unsigned PAY_W    = 64;
    localparam int unsigned PER_W    = 7;
    localparam int unsigned SCORE_W  = 8;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned RUN_W    = 16;
    localparam int unsigned TOTAL_W  = 64;
    localparam int unsigned IN_DATA_W  = 176;
    localparam int unsigned OUT_DATA_W = 128;

    localparam logic [KIND_W-1:0] KIND_REGION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EPOCH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_FAC  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSTABLE_FAC = 2'd3;

    localparam logic [CFG_W-1:0] RST_BASE_PERIOD  = 8'd4;
    localparam logic [CFG_W-1:0] RST_MIN_PERIOD   = 8'd3;
    localparam logic [CFG_W-1:0] RST_STABLE_FAC   = 8'd16;
    localparam logic [CFG_W-1:0] RST_UNSTABLE_FAC = 8'd24;

    localparam logic [CFG_W-1:0]   NO_CANDIDATE = 8'hFF;
    localparam logic [RUN_W-1:0]   RUN_MAX      = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MARK_RESET   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SIG_W-1:0]   signal_value;
        logic [PAY_W-1:0]   payload;
        logic [PER_W-1:0]   detected_period;
        logic [SCORE_W-1:0] period_score;
        logic [COUNT_W-1:0] record_count;
    } t_rec;

    typedef struct packed {
        logic               epoch;
        logic [TOTAL_W-1:0] total;
    } t_track;

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        sat_inc = (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
    endfunction

endpackage

@@ rtl/core/ped_in_reg.sv @@
// Input register stage: captures one record transaction and holds it until it moves on
module ped_in_reg
    import ped_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [KIND_W-1:0]    s_axis_tuser,
    input  logic                 i_move,
    output logic                 o_valid,
    output t_rec                 o_rec
);

    logic r_valid;
    t_rec r_rec;
    logic w_load;

    assign s_axis_tready = !r_valid || i_move;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_move) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rec.kind            <= s_axis_tuser;
            r_rec.signal_value    <= s_axis_tdata[63:0];
            r_rec.payload         <= s_axis_tdata[127:64];
            r_rec.detected_period <= s_axis_tdata[134:128];
            r_rec.period_score    <= s_axis_tdata[142:135];
            r_rec.record_count    <= s_axis_tdata[174:143];
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

@@ rtl/core/ped_tracker.sv @@
// Hysteresis tracker: configuration registers, lock state and epoch decision
module ped_tracker
    import ped_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_fire,
    input  t_rec                 i_rec,
    output t_track               o_track
);

    logic [CFG_W-1:0]   r_base;
    logic [CFG_W-1:0]   r_min;
    logic [CFG_W-1:0]   r_sfac;
    logic [CFG_W-1:0]   r_ufac;

    logic               r_locked, n_locked;
    logic [CFG_W-1:0]   r_cand, n_cand;
    logic [RUN_W-1:0]   r_srun, n_srun;
    logic [RUN_W-1:0]   r_urun, n_urun;
    logic [COUNT_W-1:0] r_mark, n_mark;
    logic [TOTAL_W-1:0] r_total;

    logic [CFG_W-1:0]   w_p;
    logic [15:0]        w_base_prod;
    logic [15:0]        w_stab_prod;
    logic [15:0]        w_unst_prod;
    logic [11:0]        w_unst_thr;
    logic [RUN_W-1:0]   w_srun;
    logic [RUN_W-1:0]   w_urun;
    logic [COUNT_W-1:0] w_dist;
    logic               w_hit;
    logic               w_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= RST_BASE_PERIOD;
            r_min  <= RST_MIN_PERIOD;
            r_sfac <= RST_STABLE_FAC;
            r_ufac <= RST_UNSTABLE_FAC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_PERIOD:  r_base <= i_cfg_data;
                CFG_MIN_PERIOD:   r_min  <= i_cfg_data;
                CFG_STABLE_FAC:   r_sfac <= i_cfg_data;
                CFG_UNSTABLE_FAC: r_ufac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_p         = {1'b0, i_rec.detected_period};
    assign w_base_prod = r_sfac * r_base;
    assign w_stab_prod = r_sfac * w_p;
    assign w_unst_prod = r_ufac * r_cand;
    assign w_unst_thr  = (r_cand == NO_CANDIDATE) ? 12'd0 : w_unst_prod[15:4];
    assign w_urun      = (w_p == r_cand) ? '0 : sat_inc(r_urun);
    assign w_dist      = i_rec.record_count - r_mark;

    always_comb begin
        n_locked = r_locked;
        n_cand   = r_cand;
        n_srun   = r_srun;
        n_urun   = r_urun;
        n_mark   = r_mark;
        w_srun   = r_srun;
        w_hit    = 1'b0;
        w_epoch  = 1'b0;
        if (!r_locked) begin
            if ((i_rec.period_score >= w_p) || (w_p < r_min)) begin
                n_cand = NO_CANDIDATE;
                w_srun = '0;
            end else if (w_p == r_cand) begin
                w_srun = sat_inc(r_srun);
            end else begin
                n_cand = w_p;
                w_srun = '0;
            end
            if (w_p <= r_base) begin
                w_hit = {w_srun, 4'b0000} == {4'b0000, w_base_prod};
            end else begin
                w_hit = w_srun >= {4'b0000, w_stab_prod[15:4]};
            end
            n_srun = w_srun;
            if (w_hit) begin
                n_locked = 1'b1;
                n_mark   = i_rec.record_count;
                n_srun   = '0;
                w_epoch  = 1'b1;
            end
        end else begin
            n_urun = w_urun;
            if (w_urun >= {4'b0000, w_unst_thr}) begin
                n_locked = 1'b0;
                n_urun   = '0;
            end else if ((w_p >= r_cand) && (w_dist >= {25'd0, i_rec.detected_period})) begin
                n_mark  = i_rec.record_count;
                w_epoch = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_cand   <= NO_CANDIDATE;
            r_srun   <= '0;
            r_urun   <= '0;
            r_mark   <= MARK_RESET;
            r_total  <= '0;
        end else if (i_fire && (i_rec.kind == KIND_REGION)) begin
            r_locked <= n_locked;
            r_cand   <= n_cand;
            r_srun   <= n_srun;
            r_urun   <= n_urun;
            r_mark   <= n_mark;
            if (w_epoch) begin
                r_total <= r_total + TOTAL_W'(1);
            end
        end
    end

    assign o_track.epoch = w_epoch && (i_rec.kind == KIND_REGION);
    assign o_track.total = r_total + TOTAL_W'(1);

endmodule

@@ rtl/core/ped_out_buf.sv @@
// Result register: presents the passed record and, after it when an epoch was found, the generated epoch result
module ped_out_buf
    import ped_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_rec                  i_rec,
    input  t_track                i_track,
    output logic                  o_can_load,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast
);

    logic               r_valid;
    logic               r_second;
    logic               r_two;
    logic [KIND_W-1:0]  r_kind;
    logic [SIG_W-1:0]   r_signal;
    logic [PAY_W-1:0]   r_payload;
    logic [TOTAL_W-1:0] r_total;
    logic               w_take;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_second || !r_two;
    assign m_axis_tuser  = r_second ? KIND_EPOCH : r_kind;
    assign m_axis_tdata  = {r_payload, (r_second ? r_total : r_signal)};
    assign w_take        = r_valid && m_axis_tready;
    assign o_can_load    = !r_valid || (w_take && m_axis_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
            r_two    <= 1'b0;
        end else if (i_load) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
            r_two    <= i_track.epoch;
        end else if (w_take && !m_axis_tlast) begin
            r_second <= 1'b1;
        end else if (w_take) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind    <= (i_rec.kind == KIND_REGION) ? KIND_REGION : KIND_OTHER;
            r_signal  <= i_rec.signal_value;
            r_payload <= i_rec.payload;
            r_total   <= i_track.total;
        end
    end

endmodule

@@ rtl/core/periodicity_epoch_detector.sv @@
// Top level of the periodicity epoch detector
//
// Records enter on the s_axis channel: tuser carries the event kind, tdata the
// signal word, payload, detector period, score and record count. Epoch-count
// records are dropped; every other record leaves on m_axis unchanged, with
// kind 3 reported as an other event. A region entry also advances the
// period-lock hysteresis; when it finds an epoch, a second result of kind
// epoch follows, carrying the running epoch total in the signal word, and
// tlast marks the final result of each input record.
// A record passes through the input register and then the result register,
// where the tracker's decision lands. A new record is taken every cycle
// while each record yields one result and the receiver holds tready high;
// a record with an epoch occupies the result register for two output
// transactions. Thresholds are set by the configuration port; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset (synchronous, active low) restores the default thresholds, unlocks
// the tracker and clears the epoch total. When the receiver stalls, the result
// register holds and the input register fills, then s_axis_tready drops.
module periodicity_epoch_detector
    import ped_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // signal_value, payload, detected_period, period_score, record_count, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // event_kind
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_signal, out_payload
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // out_event_kind
    output logic [KIND_W-1:0]     m_axis_tuser,
    // last_of_run
    output logic                  m_axis_tlast
);

    logic   w_in_valid;
    t_rec   w_rec;
    t_track w_track;
    logic   w_can_load;
    logic   w_move;
    logic   w_fire;

    assign w_move = w_in_valid && ((w_rec.kind == KIND_EPOCH) || w_can_load);
    assign w_fire = w_in_valid && (w_rec.kind != KIND_EPOCH) && w_can_load;

    ped_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_move        (w_move),
        .o_valid       (w_in_valid),
        .o_rec         (w_rec)
    );

    ped_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (w_fire),
        .i_rec      (w_rec),
        .o_track    (w_track)
    );

    ped_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_fire),
        .i_rec         (w_rec),
        .i_track       (w_track),
        .o_can_load    (w_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/core/ped_checker.sv @@
// Port-level checker for the periodicity epoch detector, bound to the top level
`include "periodicity_epoch_detector_macros.svh"

module ped_checker
    import ped_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]     m_axis_tuser,
    input logic                  m_axis_tlast
);

    `PED_ASSERT_NXT(a_rst_quiet, !i_rst_n, !m_axis_tvalid, "result valid right after reset")
    `PED_ASSERT_IMP(a_epoch_last, m_axis_tvalid && (m_axis_tuser == KIND_EPOCH), m_axis_tlast, "epoch result not last")
    `PED_ASSERT_IMP(a_kind_ok, m_axis_tvalid, (m_axis_tuser == KIND_REGION) || (m_axis_tuser == KIND_EPOCH) || (m_axis_tuser == KIND_OTHER), "reserved kind on output")
    `PED_ASSERT_NXT(a_epoch_follows, i_rst_n && m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == KIND_EPOCH), "epoch result missing")
    `PED_ASSERT_NXT(a_stall_hold, i_rst_n && m_axis_tvalid && !m_axis_tready, !i_rst_n || (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind periodicity_epoch_detector ped_checker u_ped_checker (.*);
